@@ src/triangle_wave_generator_core_macros.svh @@
// Assertion macros used by the checker of the triangle wave generator.
`ifndef TRIANGLE_WAVE_GENERATOR_CORE_MACROS_SVH
`define TRIANGLE_WAVE_GENERATOR_CORE_MACROS_SVH

// Checked only while the block is out of reset.
`define TWG_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TWG_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/twg_pkg.sv @@
// Types and constants shared by the triangle wave generator modules.
`timescale 1ns / 1ps

package twg_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int LEVEL_W    = 17;
	localparam int VALUE_W    = 18;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE          = 3'd0,
		REG_INITIAL_SLOPE = 3'd1,
		REG_PEAK_LEVEL    = 3'd2,
		REG_START_LEVEL   = 3'd3,
		REG_CLIP_LEVEL    = 3'd4,
		REG_STEP_RISING   = 3'd5,
		REG_STEP_FALLING  = 3'd6,
		REG_BIAS          = 3'd7
	} twg_reg_t;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] initial_slope;
		logic        [14:0] peak_level;
		logic signed [15:0] start_level;
		logic signed [15:0] clip_level;
		logic signed [8:0]  slope_step_rising;
		logic signed [8:0]  slope_step_falling;
		logic signed [15:0] bias;
	} twg_cfg_t;

endpackage

@@ src/twg_cfg.sv @@
// Configuration register file of the triangle wave generator.
`timescale 1ns / 1ps

module twg_cfg import twg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output twg_cfg_t              cfg
);

	twg_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode               <= 1'b0;
			cfg_q.initial_slope      <= 16'sd64;
			cfg_q.peak_level         <= 15'd16384;
			cfg_q.start_level        <= 16'sd0;
			cfg_q.clip_level         <= 16'sd32767;
			cfg_q.slope_step_rising  <= 9'sd0;
			cfg_q.slope_step_falling <= 9'sd0;
			cfg_q.bias               <= 16'sd0;
		end else if (wr_en) begin
			unique case (twg_reg_t'(wr_index))
				REG_MODE:          cfg_q.mode               <= wr_data[0];
				REG_INITIAL_SLOPE: cfg_q.initial_slope      <= wr_data[15:0];
				REG_PEAK_LEVEL:    cfg_q.peak_level         <= wr_data[14:0];
				REG_START_LEVEL:   cfg_q.start_level        <= wr_data[15:0];
				REG_CLIP_LEVEL:    cfg_q.clip_level         <= wr_data[15:0];
				REG_STEP_RISING:   cfg_q.slope_step_rising  <= wr_data[8:0];
				REG_STEP_FALLING:  cfg_q.slope_step_falling <= wr_data[8:0];
				REG_BIAS:          cfg_q.bias               <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/twg_osc.sv @@
// Oscillator state and its per-word update: level, slope, direction and run start.
`timescale 1ns / 1ps

module twg_osc import twg_pkg::*; #(
	parameter int SLOPE_WIDTH = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  twg_cfg_t                  cfg,
	input  logic                      step_en,
	input  logic                      last,
	output logic signed [VALUE_W-1:0] value
);

	localparam int LSUM_W = ((SLOPE_WIDTH > LEVEL_W) ? SLOPE_WIDTH : LEVEL_W) + 1;
	localparam int SSUM_W = SLOPE_WIDTH + 1;

	logic signed [LEVEL_W-1:0]     level_q, level_cur, level_clip, clip_ext, level_nxt;
	logic signed [SLOPE_WIDTH-1:0] slope_q, slope_cur, slope_nxt;
	logic                          rising_q, rising_cur, rising_nxt, fresh_q;
	logic signed [LSUM_W-1:0]      lvl_sum, lvl_tmp, peak_ext, floor_ext;
	logic signed [SSUM_W-1:0]      slope_sum, step_ext;

	always_comb begin
		// A fresh run takes its starting point from the registers for this word.
		level_cur  = fresh_q ? LEVEL_W'(cfg.start_level) : level_q;
		slope_cur  = fresh_q ? SLOPE_WIDTH'(cfg.initial_slope) : slope_q;
		rising_cur = fresh_q | rising_q;

		clip_ext   = LEVEL_W'(cfg.clip_level);
		level_clip = (level_cur < clip_ext) ? level_cur : clip_ext;
		if (cfg.mode) begin
			value = VALUE_W'(level_clip) - VALUE_W'(cfg.clip_level);
		end else begin
			value = VALUE_W'(level_clip) + VALUE_W'(cfg.bias);
		end

		lvl_sum = rising_cur ? (LSUM_W'(level_cur) + LSUM_W'(slope_cur))
		                     : (LSUM_W'(level_cur) - LSUM_W'(slope_cur));
		peak_ext  = LSUM_W'(signed'({1'b0, cfg.peak_level}));
		floor_ext = cfg.mode ? -peak_ext : '0;

		// The peak is tested first; the floor wins when the two overlap.
		lvl_tmp    = lvl_sum;
		rising_nxt = rising_cur;
		if (lvl_tmp >= peak_ext) begin
			lvl_tmp    = peak_ext;
			rising_nxt = 1'b0;
		end
		if (lvl_tmp <= floor_ext) begin
			lvl_tmp    = floor_ext;
			rising_nxt = 1'b1;
		end
		level_nxt = lvl_tmp[LEVEL_W-1:0];

		step_ext  = rising_cur ? SSUM_W'(cfg.slope_step_rising)
		                       : SSUM_W'(cfg.slope_step_falling);
		slope_sum = SSUM_W'(slope_cur) + step_ext;
		if (slope_sum[SSUM_W-1] != slope_sum[SSUM_W-2]) begin
			slope_nxt = slope_sum[SSUM_W-1] ? {1'b1, {(SLOPE_WIDTH-1){1'b0}}}
			                                : {1'b0, {(SLOPE_WIDTH-1){1'b1}}};
		end else begin
			slope_nxt = slope_sum[SLOPE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			slope_q  <= '0;
			rising_q <= 1'b1;
			fresh_q  <= 1'b1;
		end else if (step_en) begin
			level_q  <= level_nxt;
			slope_q  <= slope_nxt;
			rising_q <= rising_nxt;
			fresh_q  <= last;
		end
	end

endmodule

@@ src/twg_mix.sv @@
// Saturating adder that mixes the oscillator value into a buffer sample.
`timescale 1ns / 1ps

module twg_mix import twg_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic signed [SAMPLE_WIDTH-1:0] existing,
	input  logic signed [VALUE_W-1:0]      value,
	output logic signed [SAMPLE_WIDTH-1:0] mixed,
	output logic                           sat
);

	localparam int SUM_W = ((SAMPLE_WIDTH > VALUE_W) ? SAMPLE_WIDTH : VALUE_W) + 1;

	logic signed [SUM_W-1:0]            sum;
	logic [SUM_W-SAMPLE_WIDTH:0]        upper;

	always_comb begin
		sum   = SUM_W'(existing) + SUM_W'(value);
		// The sum fits when every bit from the output sign upwards agrees.
		upper = sum[SUM_W-1:SAMPLE_WIDTH-1];
		sat   = !((&upper) || !(|upper));
		if (sat) begin
			mixed = sum[SUM_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
			                     : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end else begin
			mixed = sum[SAMPLE_WIDTH-1:0];
		end
	end

endmodule

@@ src/triangle_wave_generator_core.sv @@
// Top level of the triangle wave generator: handshake, input stage and result register.
`timescale 1ns / 1ps

// The block takes one word per clock cycle and keeps that rate without gaps
// while the consumer takes every result. A result that waits at the output
// stalls the input once the input stage also holds a word. A word is accepted
// into an input stage; from there the oscillator update and the saturating
// mix run as a single pass of adds and compares, and the result is loaded into
// the output register when the input stage advances, which raises out_valid.
// The level and slope recurrence closes through the oscillator registers
// alone, and it sets the critical path. Register writes take effect on the
// next word processed; start_level and initial_slope are picked up at the
// start of each run.

module triangle_wave_generator_core import twg_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int SLOPE_WIDTH  = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] existing_sample,
	input  logic                           last_sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] mixed_sample,
	output logic                           clipped,
	output logic                           run_end,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data
);

	twg_cfg_t                      cfg;
	logic                          vld_s1, last_s1, adv_s1;
	logic signed [SAMPLE_WIDTH-1:0] existing_s1;
	logic signed [VALUE_W-1:0]      value;
	logic signed [SAMPLE_WIDTH-1:0] mixed;
	logic                           sat;
	logic                           out_vld_q, clipped_q, run_end_q;
	logic signed [SAMPLE_WIDTH-1:0] mixed_q;

	assign cfg_ready = 1'b1;

	twg_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The input stage moves on whenever the output register is free or being emptied.
	assign adv_s1   = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			existing_s1 <= existing_sample;
			last_s1     <= last_sample;
		end
	end

	twg_osc #(
		.SLOPE_WIDTH (SLOPE_WIDTH)
	) u_osc (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (adv_s1),
		.last    (last_s1),
		.value   (value)
	);

	twg_mix #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_mix (
		.existing (existing_s1),
		.value    (value),
		.mixed    (mixed),
		.sat      (sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mixed_q   <= mixed;
			clipped_q <= sat;
			run_end_q <= last_s1;
		end
	end

	assign out_valid    = out_vld_q;
	assign mixed_sample = mixed_q;
	assign clipped      = clipped_q;
	assign run_end      = run_end_q;

endmodule

@@ src/twg_checker.sv @@
// Port-level checker for the triangle wave generator and its bind statement.
`timescale 1ns / 1ps
`include "triangle_wave_generator_core_macros.svh"

module twg_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [SAMPLE_WIDTH-1:0] mixed_sample,
	input logic                    clipped,
	input logic                    run_end
);

	localparam logic [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	logic                    at_limit;
	logic                    stall;
	logic [SAMPLE_WIDTH+1:0] out_word;

	assign at_limit = (mixed_sample == SMP_MAX) || (mixed_sample == SMP_MIN);
	assign stall    = out_valid && !out_ready;
	assign out_word = {mixed_sample, clipped, run_end};

	// No word is shown while reset is held.
	`TWG_ASSERT_ALWAYS(a_reset_out_idle, clk, !arst_n |-> !out_valid, "out_valid high in reset")

	// A consumer that is ready must never hold back the input side.
	`TWG_ASSERT(a_ready_passes, clk, arst_n, out_ready |-> in_ready, "input blocked, output ready")

	// A clipped word sits at one of the two limits of the sample range.
	`TWG_ASSERT(a_clip_at_limit, clk, arst_n, out_valid && clipped |-> at_limit, "clip off limit")

	// A stalled result word stays in place.
	`TWG_ASSERT(a_out_hold, clk, arst_n, stall |=> out_valid && $stable(out_word), "stall changed")

endmodule

bind triangle_wave_generator_core twg_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_twg_checker (.*);
